@@ rtl/rdpd_pkg.sv @@
// package for the rotary dial pulse decoder
// holds widths, limits, phase and register index codes, reset values
// no dependencies
package rdpd_pkg;

	localparam int TICK_W   = 16;
	localparam int SAMP_W   = 4;
	localparam int COUNT_W  = 5;
	localparam int DIGIT_W  = 4;
	localparam int NIBBLES  = 16;
	localparam int BUF_W    = NIBBLES * DIGIT_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [COUNT_W-1:0] MAX_DIGITS  = 5'd16;
	localparam logic [DIGIT_W-1:0] MAX_WINDOWS = 4'd11;
	localparam logic [DIGIT_W-1:0] DIGIT_BASE  = 4'd10;

	localparam logic [TICK_W-1:0] RST_SAMPLE_INTERVAL = 16'd5;
	localparam logic [SAMP_W-1:0] RST_SAMPLES         = 4'd5;
	localparam logic [TICK_W-1:0] RST_CLOSED          = 16'd40;
	localparam logic [TICK_W-1:0] RST_GAP             = 16'd200;
	localparam logic [TICK_W-1:0] RST_TIMEOUT         = 16'd0;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_SAMPLE = 2'd1,
		PH_CLOSED = 2'd2,
		PH_GAP    = 2'd3
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_INTERVAL = 3'd0,
		REG_SAMPLES         = 3'd1,
		REG_CLOSED          = 3'd2,
		REG_GAP             = 3'd3,
		REG_TIMEOUT         = 3'd4
	} cfg_reg_t;

endpackage

@@ rtl/rdpd_if.sv @@
// channel interfaces of the rotary dial pulse decoder
// depends on rdpd_pkg

// contact level beats
interface rdpd_dial_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink   (input valid, input pin_level, output ready);
endinterface

// published number beats
interface rdpd_result_if;
	logic                                valid;
	logic                                ready;
	logic [rdpd_pkg::BUF_W-1:0]          digits;
	logic [rdpd_pkg::COUNT_W-1:0]        digit_count;
	logic                                overflowed;

	modport source (output valid, output digits, output digit_count, output overflowed,
		input ready);
	modport sink   (input valid, input digits, input digit_count, input overflowed,
		output ready);
endinterface

@@ rtl/rotary_dial_pulse_decoder.sv @@
// rotary dial pulse decoder top level
// depends on rdpd_pkg and the channel interfaces in rdpd_if.sv

// each dial beat is one tick of the contact level (1 open, 0 closed). a rising
// edge while idle starts a digit: pulse windows of samples_per_window samples
// spaced sample_interval_ticks apart, each window with a high sample counting one
// pulse and followed by closed_ticks of waiting, up to eleven windows. the first
// all-low window ends the digit (pulse count mod 10, no pulses means a glitch and
// no digit). up to sixteen digits pack into the buffer, first digit in the lowest
// nibble; extra digits are dropped and overflowed is set. the buffer is published
// as one result beat at once when timeout_ticks is zero, else when the timeout
// restarted by every digit runs out while idle; gap_ticks of dead time follow
// every digit and every publish. one dial beat is taken every cycle: the beat
// sits in an input register, the decode of a tick is a single pass of counter
// compares into the state and result registers, so a result passes the input
// register, then the result register, which decouples the sides; the dial
// side only stalls when a finished result is still waiting and another is due.
// configuration is a plain write port and should only change while idle.
module rotary_dial_pulse_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	rdpd_dial_if.sink                           dial,
	rdpd_result_if.source                       result,
	input  logic                                cfg_we,
	input  logic [rdpd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rdpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// configuration registers
	logic [rdpd_pkg::TICK_W-1:0] interval_cfg_q;
	logic [rdpd_pkg::SAMP_W-1:0] samples_cfg_q;
	logic [rdpd_pkg::TICK_W-1:0] closed_cfg_q;
	logic [rdpd_pkg::TICK_W-1:0] gap_cfg_q;
	logic [rdpd_pkg::TICK_W-1:0] timeout_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_cfg_q <= rdpd_pkg::RST_SAMPLE_INTERVAL;
			samples_cfg_q  <= rdpd_pkg::RST_SAMPLES;
			closed_cfg_q   <= rdpd_pkg::RST_CLOSED;
			gap_cfg_q      <= rdpd_pkg::RST_GAP;
			timeout_cfg_q  <= rdpd_pkg::RST_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rdpd_pkg::REG_SAMPLE_INTERVAL: interval_cfg_q <= cfg_data;
				rdpd_pkg::REG_SAMPLES:         samples_cfg_q  <= cfg_data[rdpd_pkg::SAMP_W-1:0];
				rdpd_pkg::REG_CLOSED:          closed_cfg_q   <= cfg_data;
				rdpd_pkg::REG_GAP:             gap_cfg_q      <= cfg_data;
				rdpd_pkg::REG_TIMEOUT:         timeout_cfg_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero interval and zero sample count behave as one
	logic [rdpd_pkg::TICK_W-1:0] interval;
	logic [rdpd_pkg::SAMP_W-1:0] nsamp;
	assign interval = (interval_cfg_q == '0) ? rdpd_pkg::TICK_W'(1) : interval_cfg_q;
	assign nsamp    = (samples_cfg_q == '0) ? rdpd_pkg::SAMP_W'(1) : samples_cfg_q;

	// input register and handshake
	logic dial_valid_s1;
	logic pin_s1;
	logic res_valid_q;
	logic advance;

	assign dial.ready = !dial_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dial_valid_s1 <= 1'b0;
		end else if (dial.ready) begin
			dial_valid_s1 <= dial.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dial.ready && dial.valid) begin
			pin_s1 <= dial.pin_level;
		end
	end

	// decoder state
	rdpd_pkg::phase_t                phase_q, phase_d;
	logic [rdpd_pkg::TICK_W-1:0]     ticks_q, ticks_d;
	logic [rdpd_pkg::SAMP_W-1:0]     sidx_q, sidx_d;
	logic                            saw_high_q, saw_high_d;
	logic [rdpd_pkg::DIGIT_W-1:0]    pulses_q, pulses_d;
	logic [rdpd_pkg::BUF_W-1:0]      buf_q, buf_d;
	logic [rdpd_pkg::COUNT_W-1:0]    count_q, count_d;
	logic                            ovf_q, ovf_d;
	logic [rdpd_pkg::TICK_W-1:0]     tleft_q, tleft_d;
	logic                            armed_q, armed_d;
	logic                            expired_q, expired_d;
	logic                            prev_q;

	// single pass decode of one tick
	logic                            rising;
	logic [rdpd_pkg::TICK_W-1:0]     ticks_inc;
	logic                            idle_check;
	logic                            closed_end;
	logic                            finish;
	logic                            publish;
	logic [rdpd_pkg::DIGIT_W-1:0]    digit;
	logic [rdpd_pkg::BUF_W-1:0]      pub_digits;
	logic [rdpd_pkg::COUNT_W-1:0]    pub_count;
	logic                            pub_ovf;

	assign rising    = pin_s1 && !prev_q;
	assign ticks_inc = ticks_q + rdpd_pkg::TICK_W'(1);

	always_comb begin
		phase_d    = phase_q;
		ticks_d    = ticks_q;
		sidx_d     = sidx_q;
		saw_high_d = saw_high_q;
		pulses_d   = pulses_q;
		buf_d      = buf_q;
		count_d    = count_q;
		ovf_d      = ovf_q;
		tleft_d    = tleft_q;
		armed_d    = armed_q;
		expired_d  = expired_q;
		idle_check = 1'b0;
		closed_end = 1'b0;
		finish     = 1'b0;
		publish    = 1'b0;
		digit      = '0;
		pub_digits = '0;
		pub_count  = '0;
		pub_ovf    = 1'b0;

		// one-shot timeout runs in every phase
		if (armed_q) begin
			tleft_d = tleft_q - rdpd_pkg::TICK_W'(1);
			if (tleft_d == '0) begin
				armed_d   = 1'b0;
				expired_d = 1'b1;
			end
		end

		unique case (phase_q)
			rdpd_pkg::PH_GAP: begin
				if (ticks_inc >= gap_cfg_q) begin
					phase_d    = rdpd_pkg::PH_IDLE;
					ticks_d    = '0;
					idle_check = 1'b1;
				end else begin
					ticks_d = ticks_inc;
				end
			end
			rdpd_pkg::PH_IDLE: begin
				idle_check = 1'b1;
			end
			rdpd_pkg::PH_SAMPLE: begin
				if (ticks_inc < interval) begin
					ticks_d = ticks_inc;
				end else begin
					ticks_d = '0;
					if (sidx_q < nsamp) begin
						saw_high_d = saw_high_q | pin_s1;
						sidx_d     = sidx_q + rdpd_pkg::SAMP_W'(1);
					end else if (!saw_high_q) begin
						finish = 1'b1;
					end else begin
						pulses_d   = pulses_q + rdpd_pkg::DIGIT_W'(1);
						saw_high_d = 1'b0;
						sidx_d     = '0;
						if (closed_cfg_q == '0) begin
							closed_end = 1'b1;
						end else begin
							phase_d = rdpd_pkg::PH_CLOSED;
						end
					end
				end
			end
			rdpd_pkg::PH_CLOSED: begin
				ticks_d = ticks_inc;
				if (ticks_inc >= closed_cfg_q) begin
					closed_end = 1'b1;
				end
			end
			default: ;
		endcase

		// end of closed wait: next window, or the digit ends after the last window
		if (closed_end) begin
			if (pulses_d >= rdpd_pkg::MAX_WINDOWS) begin
				finish = 1'b1;
			end else begin
				saw_high_d = pin_s1;
				sidx_d     = rdpd_pkg::SAMP_W'(1);
				ticks_d    = '0;
				phase_d    = rdpd_pkg::PH_SAMPLE;
			end
		end

		// idle: pending publish wins over a new edge
		if (idle_check) begin
			if (expired_d) begin
				publish = 1'b1;
				ticks_d = '0;
				phase_d = (gap_cfg_q == '0) ? rdpd_pkg::PH_IDLE : rdpd_pkg::PH_GAP;
			end else if (rising) begin
				pulses_d   = '0;
				saw_high_d = pin_s1;
				sidx_d     = rdpd_pkg::SAMP_W'(1);
				ticks_d    = '0;
				phase_d    = rdpd_pkg::PH_SAMPLE;
			end
		end

		// digit end: store the digit, restart the timeout or publish at once
		if (finish) begin
			if (pulses_d != '0) begin
				digit = (pulses_d >= rdpd_pkg::DIGIT_BASE) ?
					pulses_d - rdpd_pkg::DIGIT_BASE : pulses_d;
				if (count_q < rdpd_pkg::MAX_DIGITS) begin
					for (int i = 0; i < rdpd_pkg::NIBBLES; i++) begin
						if (count_q[rdpd_pkg::DIGIT_W-1:0] == rdpd_pkg::DIGIT_W'(i)) begin
							buf_d[i*rdpd_pkg::DIGIT_W +: rdpd_pkg::DIGIT_W] =
								buf_q[i*rdpd_pkg::DIGIT_W +: rdpd_pkg::DIGIT_W] | digit;
						end
					end
					count_d = count_q + rdpd_pkg::COUNT_W'(1);
				end else begin
					ovf_d = 1'b1;
				end
				if (timeout_cfg_q != '0) begin
					tleft_d = timeout_cfg_q;
					armed_d = 1'b1;
				end else begin
					publish = 1'b1;
				end
			end
			pulses_d   = '0;
			sidx_d     = '0;
			saw_high_d = 1'b0;
			ticks_d    = '0;
			phase_d    = (gap_cfg_q == '0) ? rdpd_pkg::PH_IDLE : rdpd_pkg::PH_GAP;
		end

		// publish takes the buffer as it stands and clears it
		if (publish) begin
			pub_digits = buf_d;
			pub_count  = count_d;
			pub_ovf    = ovf_d;
			buf_d      = '0;
			count_d    = '0;
			ovf_d      = 1'b0;
			expired_d  = 1'b0;
		end
	end

	// a tick waits only when it would publish over a result still waiting
	assign advance = dial_valid_s1 && (!res_valid_q || result.ready || !publish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= rdpd_pkg::PH_IDLE;
			ticks_q    <= '0;
			sidx_q     <= '0;
			saw_high_q <= 1'b0;
			pulses_q   <= '0;
			buf_q      <= '0;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			tleft_q    <= '0;
			armed_q    <= 1'b0;
			expired_q  <= 1'b0;
			prev_q     <= 1'b0;
		end else if (advance) begin
			phase_q    <= phase_d;
			ticks_q    <= ticks_d;
			sidx_q     <= sidx_d;
			saw_high_q <= saw_high_d;
			pulses_q   <= pulses_d;
			buf_q      <= buf_d;
			count_q    <= count_d;
			ovf_q      <= ovf_d;
			tleft_q    <= tleft_d;
			armed_q    <= armed_d;
			expired_q  <= expired_d;
			prev_q     <= pin_s1;
		end
	end

	// result register
	logic [rdpd_pkg::BUF_W-1:0]   res_digits_q;
	logic [rdpd_pkg::COUNT_W-1:0] res_count_q;
	logic                         res_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && publish) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && publish) begin
			res_digits_q <= pub_digits;
			res_count_q  <= pub_count;
			res_ovf_q    <= pub_ovf;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.digits      = res_digits_q;
	assign result.digit_count = res_count_q;
	assign result.overflowed  = res_ovf_q;

endmodule
